>>> rtl/core/dtpc_pkg.sv
`timescale 1ns / 1ps

package dtpc_pkg;

    // Fixed field widths of the transaction payload
    localparam int NODE_INDEX_W = 4;
    localparam int BAND_SEL_W   = 2;
    localparam int THRESH_W     = 16;
    localparam int FIELD_BANDS  = 4;
    localparam int CODE_W       = 5;

    // Action codes
    localparam logic ACT_CLASSIFY = 1'b0;
    localparam logic ACT_WRITE    = 1'b1;

    // Class code reported when a band on the path has no data or does not exist
    localparam logic signed [CODE_W-1:0] NO_CLASS = '1;

    // One decision node as held in the tree table
    typedef struct packed {
        logic                       high_inner;
        logic                       low_inner;
        logic signed [THRESH_W-1:0] threshold;
        logic [BAND_SEL_W-1:0]      band;
    } node_t;

endpackage

>>> rtl/core/decision_tree_pixel_classifier.sv
`timescale 1ns / 1ps
// Items enter stage register 0 and move down the stage registers to the output register.
// Throughput: one transaction per cycle while no result is held; one tree level is resolved per stage,
// and each level below NUM_BANKS keeps its own node bank, so stage k reads only level k of the tree.
// Node writes travel the pipeline and update their level's bank in order; they give no result.
// Reset (rst_n low, asynchronous) empties the pipeline and clears every node to band 0,
// threshold 0, both children leaves.
module decision_tree_pixel_classifier
    import dtpc_pkg::*;
#(
    parameter int MAX_DEPTH    = 4,
    parameter int BANDS        = 4,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [NODE_INDEX_W-1:0]        node_index,
    input  logic [BAND_SEL_W-1:0]          node_band,
    input  logic signed [THRESH_W-1:0]     node_threshold,
    input  logic                           node_low_inner,
    input  logic                           node_high_inner,
    input  logic signed [SAMPLE_WIDTH-1:0] band_zero,
    input  logic signed [SAMPLE_WIDTH-1:0] band_one,
    input  logic signed [SAMPLE_WIDTH-1:0] band_two,
    input  logic signed [SAMPLE_WIDTH-1:0] band_three,
    input  logic [FIELD_BANDS-1:0]         nodata_mask,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [CODE_W-1:0]       class_code
);

    // Levels that a node write can reach (heap index fits NODE_INDEX_W bits)
    localparam int NUM_BANKS = (MAX_DEPTH < NODE_INDEX_W) ? MAX_DEPTH : NODE_INDEX_W;
    localparam int CMP_W     = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
    localparam int BCMP_W    = 5;

    typedef struct packed {
        logic                                     wr;
        logic [NODE_INDEX_W-1:0]                  widx;
        node_t                                    wnode;
        logic [FIELD_BANDS-1:0][SAMPLE_WIDTH-1:0] bands;
        logic [FIELD_BANDS-1:0]                   mask;
        logic [MAX_DEPTH-1:0]                     code;
        logic                                     done;
        logic                                     nodata;
    } stage_t;

    logic   [MAX_DEPTH:0] valid_reg;
    stage_t               stage_reg  [MAX_DEPTH+1];
    stage_t               stage_next [MAX_DEPTH+1];
    logic                 adv;

    // Advance the whole pipeline unless a finished result is held
    assign out_valid = valid_reg[MAX_DEPTH] && (stage_reg[MAX_DEPTH].wr != ACT_WRITE);
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;

    // Build the entry stage from the input transaction
    always_comb
    begin
        stage_next[0].wr                   = (action == ACT_WRITE);
        stage_next[0].widx                 = node_index;
        stage_next[0].wnode.band           = node_band;
        stage_next[0].wnode.threshold      = node_threshold;
        stage_next[0].wnode.low_inner      = node_low_inner;
        stage_next[0].wnode.high_inner     = node_high_inner;
        stage_next[0].bands                = {band_three, band_two, band_one, band_zero};
        stage_next[0].mask                 = nodata_mask;
        stage_next[0].code                 = '0;
        stage_next[0].done                 = 1'b0;
        stage_next[0].nodata               = 1'b0;
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[MAX_DEPTH-1:0], in_valid};
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= MAX_DEPTH; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    genvar k, j;
    generate
        for (k = 0; k < MAX_DEPTH; k++)
        begin : g_lvl
            localparam logic LAST = (k + 1 >= MAX_DEPTH);

            node_t                         node_rd;
            logic                          wr_hit;
            logic                          band_bad;
            logic signed [SAMPLE_WIDTH-1:0] sample;
            logic signed [CMP_W-1:0]       sample_ext;
            logic signed [CMP_W-1:0]       thr_ext;
            logic                          go_high;
            logic                          inner;

            // Write this level's bank when a node write reaches this stage
            assign wr_hit = adv && valid_reg[k] && stage_reg[k].wr
                         && ((stage_reg[k].widx >> k) == NODE_INDEX_W'(1));

            if (k < NUM_BANKS)
            begin : g_bank
                if (k == 0)
                begin : g_root
                    node_t root_reg;

                    always_ff @(posedge clk or negedge rst_n)
                    begin
                        if (!rst_n)
                        begin
                            root_reg <= '0;
                        end
                        else if (wr_hit)
                        begin
                            root_reg <= stage_reg[k].wnode;
                        end
                    end

                    assign node_rd = root_reg;
                end
                else
                begin : g_mem
                    node_t        mem_reg [2**k];
                    logic [k-1:0] rd_addr;
                    logic [k-1:0] wr_addr;

                    // Path so far, root decision in the top address bit
                    for (j = 0; j < k; j++)
                    begin : g_addr
                        assign rd_addr[k-1-j] = stage_reg[k].code[j];
                    end
                    assign wr_addr = stage_reg[k].widx[k-1:0];

                    always_ff @(posedge clk or negedge rst_n)
                    begin
                        if (!rst_n)
                        begin
                            for (int e = 0; e < 2**k; e++)
                            begin
                                mem_reg[e] <= '0;
                            end
                        end
                        else if (wr_hit)
                        begin
                            mem_reg[wr_addr] <= stage_reg[k].wnode;
                        end
                    end

                    assign node_rd = mem_reg[rd_addr];
                end
            end
            else
            begin : g_none
                // Levels beyond the writable index range hold reset nodes
                assign node_rd = '0;
            end

            // Compare the selected band against this level's threshold
            assign band_bad   = ({{(BCMP_W-BAND_SEL_W){1'b0}}, node_rd.band} >= BCMP_W'(BANDS))
                             || stage_reg[k].mask[node_rd.band];
            assign sample     = stage_reg[k].bands[node_rd.band];
            assign sample_ext = CMP_W'(sample);
            assign thr_ext    = CMP_W'(node_rd.threshold);
            assign go_high    = (sample_ext >= thr_ext);
            assign inner      = go_high ? node_rd.high_inner : node_rd.low_inner;

            // Resolve one decision, or pass a node write or an item whose walk has ended on unchanged
            always_comb
            begin
                stage_next[k+1] = stage_reg[k];
                if (!stage_reg[k].wr && !stage_reg[k].done)
                begin
                    if (band_bad)
                    begin
                        stage_next[k+1].done   = 1'b1;
                        stage_next[k+1].nodata = 1'b1;
                    end
                    else
                    begin
                        stage_next[k+1].code[k] = go_high;
                        if (!inner || LAST)
                        begin
                            stage_next[k+1].done = 1'b1;
                        end
                    end
                end
            end
        end
    endgenerate

    // Drive the result from the output register
    assign class_code = stage_reg[MAX_DEPTH].nodata ? NO_CLASS
                                                    : CODE_W'(stage_reg[MAX_DEPTH].code);

endmodule
